@@ design/mic_pkg.sv @@
// Shared constants, codes and types of the MIPS integer core step block.
package mic_pkg;

	localparam int DATA_WORDS = 1024;
	localparam int REG_COUNT  = 32;
	localparam int RF_AW      = $clog2(REG_COUNT);
	localparam int DM_AW      = $clog2(DATA_WORDS);
	localparam logic [29:0] DM_LIMIT = 30'(DATA_WORDS);

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OVF = 2'd1,
		ST_MEM = 2'd2,
		ST_BAD = 2'd3
	} status_t;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_SLTIU   = 6'h0B;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_SW      = 6'h2B;

	// function codes of SPECIAL
	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_SRA  = 6'h03;
	localparam logic [5:0] FN_SLLV = 6'h04;
	localparam logic [5:0] FN_SRLV = 6'h06;
	localparam logic [5:0] FN_SRAV = 6'h07;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_SLT  = 6'h2A;
	localparam logic [5:0] FN_SLTU = 6'h2B;

	typedef struct packed {
		status_t          status;
		logic             wr;
		logic [RF_AW-1:0] idx;
		logic [31:0]      val;
		logic             taken;
		logic [31:0]      step;
		logic             load;
		logic             lbu;
		logic             store;
		logic [DM_AW-1:0] mem_idx;
		logic [1:0]       byte_sel;
	} exec_res_t;

endpackage

@@ design/mic_ram.sv @@
// Generic simple dual-port RAM with registered read.
module mic_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/mic_exec.sv @@
// Decode and ALU: computes the effect of one instruction from its operands.
module mic_exec import mic_pkg::*; (
	input  logic [31:0] instr,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output exec_res_t   res
);

	logic [5:0]       op;
	logic [5:0]       fn;
	logic [4:0]       rs_sh;
	logic [4:0]       sh;
	logic [RF_AW-1:0] rt;
	logic [RF_AW-1:0] rd;
	logic [31:0]      imm;
	logic [31:0]      simm;
	logic [31:0]      sum_ab;
	logic [31:0]      dif_ab;
	logic [31:0]      sum_ai;
	logic             misal;
	logic             oor;

	assign op     = instr[31:26];
	assign fn     = instr[5:0];
	assign rt     = instr[20:16];
	assign rd     = instr[15:11];
	assign sh     = instr[10:6];
	assign rs_sh  = a[4:0];
	assign imm    = {16'd0, instr[15:0]};
	assign simm   = {{16{instr[15]}}, instr[15:0]};
	assign sum_ab = a + b;
	assign dif_ab = a - b;
	assign sum_ai = a + simm;
	assign misal  = sum_ai[1:0] != 2'd0;
	assign oor    = sum_ai[31:2] >= DM_LIMIT;

	always_comb begin
		res          = '0;
		res.status   = ST_OK;
		res.idx      = rt;
		res.mem_idx  = sum_ai[DM_AW+1:2];
		res.byte_sel = sum_ai[1:0];
		if (op == OP_SPECIAL) begin
			res.idx = rd;
			res.wr  = 1'b1;
			unique case (fn)
				FN_SLL:  res.val = b << sh;
				FN_SRL:  res.val = b >> sh;
				FN_SRA:  res.val = 32'($signed(b) >>> sh);
				FN_SLLV: res.val = b << rs_sh;
				FN_SRLV: res.val = b >> rs_sh;
				FN_SRAV: res.val = 32'($signed(b) >>> rs_sh);
				FN_ADD: begin
					res.val = sum_ab;
					if (a[31] == b[31] && sum_ab[31] != a[31]) begin
						res.status = ST_OVF;
					end
				end
				FN_ADDU: res.val = sum_ab;
				FN_SUB: begin
					res.val = dif_ab;
					if (a[31] != b[31] && dif_ab[31] != a[31]) begin
						res.status = ST_OVF;
					end
				end
				FN_SUBU: res.val = dif_ab;
				FN_AND:  res.val = a & b;
				FN_OR:   res.val = a | b;
				FN_XOR:  res.val = a ^ b;
				FN_SLT:  res.val = {31'd0, $signed(a) < $signed(b)};
				FN_SLTU: res.val = {31'd0, a < b};
				default: res.status = ST_BAD;
			endcase
		end else begin
			unique case (op)
				OP_BEQ: res.taken = a == b;
				OP_ADDI: begin
					res.wr  = 1'b1;
					res.val = sum_ai;
					if (a[31] == simm[31] && sum_ai[31] != a[31]) begin
						res.status = ST_OVF;
					end
				end
				OP_ADDIU: begin
					res.wr  = 1'b1;
					res.val = sum_ai;
				end
				OP_SLTI: begin
					res.wr  = 1'b1;
					res.val = {31'd0, $signed(a) < $signed(simm)};
				end
				OP_SLTIU: begin
					res.wr  = 1'b1;
					res.val = {31'd0, a < simm};
				end
				OP_ANDI: begin
					res.wr  = 1'b1;
					res.val = a & imm;
				end
				OP_ORI: begin
					res.wr  = 1'b1;
					res.val = a | imm;
				end
				OP_XORI: begin
					res.wr  = 1'b1;
					res.val = a ^ imm;
				end
				OP_LUI: begin
					res.wr  = 1'b1;
					res.val = {instr[15:0], 16'd0};
				end
				OP_LW: begin
					if (misal || oor) begin
						res.status = ST_MEM;
					end else begin
						res.wr   = 1'b1;
						res.load = 1'b1;
					end
				end
				OP_LBU: begin
					if (oor) begin
						res.status = ST_MEM;
					end else begin
						res.wr   = 1'b1;
						res.load = 1'b1;
						res.lbu  = 1'b1;
					end
				end
				OP_SW: begin
					if (misal || oor) begin
						res.status = ST_MEM;
					end else begin
						res.store = 1'b1;
					end
				end
				default: res.status = ST_BAD;
			endcase
		end

		if (res.status != ST_OK) begin
			res.wr    = 1'b0;
			res.taken = 1'b0;
			res.load  = 1'b0;
			res.store = 1'b0;
		end
		// writes to r0 are dropped
		if (res.idx == '0) begin
			res.wr = 1'b0;
		end
		if (!res.wr) begin
			res.idx  = '0;
			res.val  = '0;
			res.load = 1'b0;
		end
		res.step = res.taken ? {simm[29:0], 2'b00} : 32'd4;
	end

endmodule

@@ design/mips_integer_core_step.sv @@
// Two-stage MIPS32 integer subset core that retires one instruction per transfer.
// One instruction word is taken per cycle unless out_stall holds the pipe; sustained rate
// is one instruction per cycle without output stalls. Stage one reads the register file
// (two 32-entry RAM copies with registered read, plus forwarding from the instruction ahead
// and the write that coincided with the read), runs the ALU, updates pc/next pc, checks the
// memory address and issues the data memory access; stage two picks the load data from the
// data memory's registered read port and writes the register file. fetch_address is the pc
// of the next word to present. Data memory contents are undefined until written; the
// register file reads as zero after reset.
module mips_integer_core_step import mic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] fetch_address,
	output logic        reg_written,
	output logic [4:0]  dest_index,
	output logic [31:0] dest_value,
	output logic        branch_taken
);

	logic                 valid_s1;
	logic [31:0]          instr_s1;
	logic                 valid_s2;
	exec_res_t            res_s2;
	logic [31:0]          fetch_s2;
	logic [31:0]          pc_q;
	logic [31:0]          nf_q;
	logic [REG_COUNT-1:0] rf_valid_q;
	logic                 fwd_en_q;
	logic [RF_AW-1:0]     fwd_idx_q;
	logic [31:0]          fwd_val_q;

	logic             accept;
	logic             s1_go;
	logic             s2_free;
	logic             rf_we;
	logic [31:0]      rd_a;
	logic [31:0]      rd_b;
	logic [31:0]      op_a;
	logic [31:0]      op_b;
	logic [RF_AW-1:0] rs_s1;
	logic [RF_AW-1:0] rt_s1;
	exec_res_t        ex;
	logic             dm_we;
	logic             dm_re;
	logic [31:0]      dm_rdata;
	logic [7:0]       ld_byte;
	logic [31:0]      wb_val;

	// handshake
	assign s2_free  = !valid_s2 || !out_stall;
	assign s1_go    = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;

	// register file copies, one per read port
	assign rf_we = valid_s2 && !out_stall && res_s2.wr;

	mic_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (res_s2.idx),
		.wdata (wb_val),
		.re    (accept),
		.raddr (instr_word[25:21]),
		.rdata (rd_a)
	);

	mic_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (res_s2.idx),
		.wdata (wb_val),
		.re    (accept),
		.raddr (instr_word[20:16]),
		.rdata (rd_b)
	);

	assign rs_s1 = instr_s1[25:21];
	assign rt_s1 = instr_s1[20:16];

	// operand select: newest in-flight write first, then the write that raced the read
	always_comb begin
		if (rs_s1 == '0) begin
			op_a = '0;
		end else if (valid_s2 && res_s2.wr && res_s2.idx == rs_s1) begin
			op_a = wb_val;
		end else if (fwd_en_q && fwd_idx_q == rs_s1) begin
			op_a = fwd_val_q;
		end else if (rf_valid_q[rs_s1]) begin
			op_a = rd_a;
		end else begin
			op_a = '0;
		end
	end

	always_comb begin
		if (rt_s1 == '0) begin
			op_b = '0;
		end else if (valid_s2 && res_s2.wr && res_s2.idx == rt_s1) begin
			op_b = wb_val;
		end else if (fwd_en_q && fwd_idx_q == rt_s1) begin
			op_b = fwd_val_q;
		end else if (rf_valid_q[rt_s1]) begin
			op_b = rd_b;
		end else begin
			op_b = '0;
		end
	end

	mic_exec u_exec (
		.instr (instr_s1),
		.a     (op_a),
		.b     (op_b),
		.res   (ex)
	);

	// data memory
	assign dm_we = s1_go && ex.store;
	assign dm_re = s1_go && ex.load;

	mic_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
		.clk   (clk),
		.we    (dm_we),
		.waddr (ex.mem_idx),
		.wdata (op_b),
		.re    (dm_re),
		.raddr (ex.mem_idx),
		.rdata (dm_rdata)
	);

	// big-endian byte lanes: byte 0 is the top byte
	always_comb begin
		case (res_s2.byte_sel)
			2'd0:    ld_byte = dm_rdata[31:24];
			2'd1:    ld_byte = dm_rdata[23:16];
			2'd2:    ld_byte = dm_rdata[15:8];
			default: ld_byte = dm_rdata[7:0];
		endcase
	end

	always_comb begin
		if (!res_s2.wr) begin
			wb_val = '0;
		end else if (res_s2.load) begin
			wb_val = res_s2.lbu ? {24'd0, ld_byte} : dm_rdata;
		end else begin
			wb_val = res_s2.val;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			pc_q       <= 32'd0;
			nf_q       <= 32'd4;
			rf_valid_q <= '0;
			fwd_en_q   <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !s1_go);
			valid_s2 <= s1_go || (valid_s2 && out_stall);
			if (s1_go && ex.status == ST_OK) begin
				pc_q <= nf_q;
				nf_q <= nf_q + ex.step;
			end
			if (rf_we) begin
				rf_valid_q[res_s2.idx] <= 1'b1;
			end
			if (accept) begin
				fwd_en_q <= rf_we;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1  <= instr_word;
			fwd_idx_q <= res_s2.idx;
			fwd_val_q <= wb_val;
		end
		if (s1_go) begin
			res_s2   <= ex;
			fetch_s2 <= (ex.status == ST_OK) ? nf_q : pc_q;
		end
	end

	assign out_valid     = valid_s2;
	assign status        = res_s2.status;
	assign fetch_address = fetch_s2;
	assign reg_written   = res_s2.wr;
	assign dest_index    = res_s2.idx;
	assign dest_value    = wb_val;
	assign branch_taken  = res_s2.taken;

	a_err_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> !reg_written && !branch_taken)
		else $error("error status with register write or taken branch");

	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_written |-> dest_index != 5'd0)
		else $error("register write reported for r0");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a full pipeline");

	a_dmem_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(dm_we && dm_re))
		else $error("data memory read and write in one cycle");

endmodule
